@@ rtl/stable_priority_queue_core_macros.svh @@
// Assertion macros shared by the queue RTL.
// Each expects signals named clk and rst in the scope of use.
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed: next-cycle implication");

`endif

@@ rtl/slpq_pkg.sv @@
package slpq_pkg;

  localparam int unsigned PRIO_W   = 17;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 7;
  localparam logic [PRIO_W-1:0] PRIO_ONE = 17'd65536;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_POP = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_ADDED     = 2'd0,
    STAT_POPPED    = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL_DROP = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
  } entry_t;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [WORD_W-1:0] payload_w0;
    logic [WORD_W-1:0] payload_w1;
    logic [WORD_W-1:0] payload_w2;
    logic [WORD_W-1:0] payload_w3;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PRIO_W-1:0]  out_priority;
    logic [WORD_W-1:0]  out_word0;
    logic [WORD_W-1:0]  out_word1;
    logic [WORD_W-1:0]  out_word2;
    logic [WORD_W-1:0]  out_word3;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // Broadcast control for every cell in the chain
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

@@ rtl/slpq_cell.sv @@
module slpq_cell (
  input  logic               clk,
  input  slpq_pkg::cell_ctl_t ctl,
  input  slpq_pkg::entry_t   new_entry,
  input  slpq_pkg::entry_t   left_entry,
  input  slpq_pkg::entry_t   right_entry,
  input  logic               left_after,
  input  logic               occupied,
  output slpq_pkg::entry_t   entry,
  output logic               after
);

  // Entry stays ahead of the incoming one when it is lower or equal
  assign after = occupied && (entry.prio <= new_entry.prio);

  // Hold, take the new entry, shift from the left, or shift from the right
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!after) begin
        entry <= left_after ? new_entry : left_entry;
      end
    end else if (ctl.remove) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/stable_priority_queue_core.sv @@
// Bounded min-priority queue built as a row of CAPACITY shift cells kept in
// sorted order, lowest priority in cell 0. For each request (add or pop),
// every cell compares its priority with the new one in parallel and then
// holds, loads the new entry, or takes its neighbor's, so one request can be
// accepted every clock while req_stall is low. The result is registered and
// appears on the cycle after acceptance; req_stall is high only while a
// result waits under rsp_stall. Equal priorities leave in arrival order. An
// add to a full queue is dropped and reported; a pop on an empty queue is
// reported and changes nothing. Priorities above 65536 are saturated to 65536.
`include "stable_priority_queue_core_macros.svh"

module stable_priority_queue_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  slpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slpq_pkg::rsp_t rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                is_pop;
  logic                full;
  logic                empty;
  slpq_pkg::entry_t    new_entry;
  slpq_pkg::cell_ctl_t ctl;
  slpq_pkg::entry_t    cells [CAPACITY];
  logic [CAPACITY-1:0] after;
  slpq_pkg::rsp_t      rsp_next;
  logic [CW+6:0]       count_ext;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign is_pop    = (req.req_type == slpq_pkg::REQ_POP);
  assign full      = (count >= CW'(CAPACITY));
  assign empty     = (count == '0);

  // Saturate the priority and form the incoming entry
  always_comb begin
    new_entry.prio  = (req.priority_req > slpq_pkg::PRIO_ONE) ?
                      slpq_pkg::PRIO_ONE : req.priority_req;
    new_entry.word0 = req.payload_w0;
    new_entry.word1 = req.payload_w1;
    new_entry.word2 = req.payload_w2;
    new_entry.word3 = req.payload_w3;
  end

  // Drive the cell chain
  always_comb begin
    ctl.insert = accept && !is_pop && !full;
    ctl.remove = accept && is_pop && !empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slpq_pkg::entry_t left_e;
    slpq_pkg::entry_t right_e;
    logic             left_a;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_a = 1'b1;
    end else begin : g_body
      assign left_e = cells[i-1];
      assign left_a = after[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cells[i];
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    slpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_after  (left_a),
      .occupied    (count > CW'(i)),
      .entry       (cells[i]),
      .after       (after[i])
    );
  end

  // Count update
  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CW'(1);
    end else if (ctl.remove) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = (CW+7)'(count_next);

  // Build the result
  always_comb begin
    rsp_next              = '0;
    rsp_next.entry_count  = count_ext[6:0];
    if (is_pop) begin
      if (empty) begin
        rsp_next.status = slpq_pkg::STAT_EMPTY;
      end else begin
        rsp_next.status       = slpq_pkg::STAT_POPPED;
        rsp_next.out_priority = cells[0].prio;
        rsp_next.out_word0    = cells[0].word0;
        rsp_next.out_word1    = cells[0].word1;
        rsp_next.out_word2    = cells[0].word2;
        rsp_next.out_word3    = cells[0].word3;
      end
    end else begin
      rsp_next.status = full ? slpq_pkg::STAT_FULL_DROP : slpq_pkg::STAT_ADDED;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result register, loaded on each transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_pop_decrements, accept && is_pop && !empty, count == $past(count) - CW'(1))
  `SPQ_ASSERT_NOW(a_head_sorted, count >= CW'(2), cells[0].prio <= cells[1].prio)
  `SPQ_ASSERT_NEXT(a_result_follows, accept, rsp_valid)

endmodule
